// ===== design/crsf_frame_receiver_assert.svh =====
// assertion macros used by the frame receiver datapath
`ifndef CRSF_FRAME_RECEIVER_ASSERT_SVH
`define CRSF_FRAME_RECEIVER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define CRSF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define CRSF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/crsf_pkg.sv =====
// shared types and constants of the frame receiver
`timescale 1ns / 1ps
`default_nettype none
package crsf_pkg;

    localparam int FRAME_BYTES = 64;
    localparam int ADDR_W      = $clog2(FRAME_BYTES);
    localparam int LEN_CAP     = ((FRAME_BYTES < 64) ? FRAME_BYTES : 64) - 2;
    localparam int POS_W       = 6;
    localparam int PADDR_W     = 5;

    typedef enum logic [1:0] {
        ST_FRAME     = 2'd0,
        ST_BAD_START = 2'd1,
        ST_BAD_LEN   = 2'd2,
        ST_CRC_ERR   = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        REG_SYNC    = 3'd0,
        REG_START_A = 3'd1,
        REG_START_B = 3'd2,
        REG_START_C = 3'd3,
        REG_MIN_LEN = 3'd4,
        REG_MAX_LEN = 3'd5,
        REG_POLY    = 3'd6
    } reg_idx_t;

    typedef enum logic [1:0] {
        WR_START = 2'd0,
        WR_LEN   = 2'd1,
        WR_DATA  = 2'd2
    } wr_sel_t;

    typedef struct packed {
        logic [7:0] sync_value;
        logic [7:0] start_value_a;
        logic [7:0] start_value_b;
        logic [7:0] start_value_c;
        logic [5:0] min_length_byte;
        logic [5:0] max_length_byte;
        logic [7:0] crc_polynomial;
    } cfg_t;

    // controller to datapath
    typedef struct packed {
        logic    wr_en;
        wr_sel_t wr_sel;
        logic    crc_step;
        logic    emit;
        status_t emit_status;
        logic    drain_issue;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic start_hit;
        logic len_ok;
        logic data_last;
        logic crc_match;
        logic drain_last;
        logic advance;
        logic slot_free;
    } sts_t;

endpackage
`default_nettype wire

// ===== design/crsf_frame_receiver.sv =====
// frame receiver top: one received byte per transaction, crc-checked frame output
// a byte is taken when in_stall is low; a reject result is in the output register the next cycle
// after a good crc byte the frame drains one byte per cycle while the output does not stall,
// and input is held off until the whole stored frame has been drained
// input and output are parted by the output register and the buffer read stage
// async reset clears control state and loads register defaults; the buffer is not cleared
`timescale 1ns / 1ps
`default_nettype none
module crsf_frame_receiver (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [crsf_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output logic                             pready,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [7:0]                  rx_byte,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic [1:0]                       status,
    output logic [7:0]                       frame_byte,
    output logic [crsf_pkg::POS_W-1:0]       byte_position,
    output logic [7:0]                       computed_crc,
    output logic                             last_of_run
);
    import crsf_pkg::*;

    cfg_t cfg;
    cmd_t cmd;
    sts_t sts;

    crsf_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    crsf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    crsf_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .cmd           (cmd),
        .sts           (sts),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .frame_byte    (frame_byte),
        .byte_position (byte_position),
        .computed_crc  (computed_crc),
        .last_of_run   (last_of_run)
    );

endmodule
`default_nettype wire

// ===== design/crsf_regs.sv =====
// apb configuration registers of the frame receiver
`timescale 1ns / 1ps
`default_nettype none
module crsf_regs (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [crsf_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output logic                             pready,
    output crsf_pkg::cfg_t                   cfg
);
    import crsf_pkg::*;

    cfg_t     cfg_reg;
    logic     wr_en;
    reg_idx_t idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[4:2]);
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sync_value      <= 8'hC8;
            cfg_reg.start_value_a   <= 8'hEA;
            cfg_reg.start_value_b   <= 8'hEC;
            cfg_reg.start_value_c   <= 8'hEE;
            cfg_reg.min_length_byte <= 6'd2;
            cfg_reg.max_length_byte <= 6'd62;
            cfg_reg.crc_polynomial  <= 8'hD5;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_SYNC:    cfg_reg.sync_value      <= pwdata[7:0];
                REG_START_A: cfg_reg.start_value_a   <= pwdata[7:0];
                REG_START_B: cfg_reg.start_value_b   <= pwdata[7:0];
                REG_START_C: cfg_reg.start_value_c   <= pwdata[7:0];
                REG_MIN_LEN: cfg_reg.min_length_byte <= pwdata[5:0];
                REG_MAX_LEN: cfg_reg.max_length_byte <= pwdata[5:0];
                REG_POLY:    cfg_reg.crc_polynomial  <= pwdata[7:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_SYNC:    prdata = {24'd0, cfg_reg.sync_value};
            REG_START_A: prdata = {24'd0, cfg_reg.start_value_a};
            REG_START_B: prdata = {24'd0, cfg_reg.start_value_b};
            REG_START_C: prdata = {24'd0, cfg_reg.start_value_c};
            REG_MIN_LEN: prdata = {26'd0, cfg_reg.min_length_byte};
            REG_MAX_LEN: prdata = {26'd0, cfg_reg.max_length_byte};
            REG_POLY:    prdata = {24'd0, cfg_reg.crc_polynomial};
            default:     prdata = 32'd0;
        endcase
    end

endmodule
`default_nettype wire

// ===== design/crsf_ctrl.sv =====
// frame receiver controller: frame phase and drain sequencing
`timescale 1ns / 1ps
`default_nettype none
module crsf_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  crsf_pkg::sts_t     sts,
    output crsf_pkg::cmd_t     cmd
);
    import crsf_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LENGTH,
        S_DATA,
        S_DRAIN
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign in_stall = (state_reg == S_DRAIN) || !sts.slot_free;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        cmd             = '0;
        cmd.wr_sel      = WR_START;
        cmd.emit_status = ST_FRAME;
        state_next      = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (sts.start_hit)
                    begin
                        cmd.wr_en  = 1'b1;
                        cmd.wr_sel = WR_START;
                        state_next = S_LENGTH;
                    end
                    else
                    begin
                        cmd.emit        = 1'b1;
                        cmd.emit_status = ST_BAD_START;
                    end
                end
            end
            S_LENGTH:
            begin
                if (accept)
                begin
                    if (sts.len_ok)
                    begin
                        cmd.wr_en  = 1'b1;
                        cmd.wr_sel = WR_LEN;
                        state_next = S_DATA;
                    end
                    else
                    begin
                        cmd.emit        = 1'b1;
                        cmd.emit_status = ST_BAD_LEN;
                        state_next      = S_IDLE;
                    end
                end
            end
            S_DATA:
            begin
                if (accept)
                begin
                    cmd.wr_en  = 1'b1;
                    cmd.wr_sel = WR_DATA;
                    if (!sts.data_last)
                    begin
                        cmd.crc_step = 1'b1;
                    end
                    else if (sts.crc_match)
                    begin
                        state_next = S_DRAIN;
                    end
                    else
                    begin
                        cmd.emit        = 1'b1;
                        cmd.emit_status = ST_CRC_ERR;
                        state_next      = S_IDLE;
                    end
                end
            end
            S_DRAIN:
            begin
                // one stored byte per cycle whenever the output side moves
                cmd.drain_issue = sts.advance;
                if (sts.advance && sts.drain_last)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

// ===== design/crsf_dp.sv =====
// frame receiver datapath: crc, counters, frame buffer and output register
`timescale 1ns / 1ps
`default_nettype none
`include "crsf_frame_receiver_assert.svh"
module crsf_dp (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  crsf_pkg::cfg_t                   cfg,
    input  crsf_pkg::cmd_t                   cmd,
    output crsf_pkg::sts_t                   sts,
    input  wire logic [7:0]                  rx_byte,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic [1:0]                       status,
    output logic [7:0]                       frame_byte,
    output logic [crsf_pkg::POS_W-1:0]       byte_position,
    output logic [7:0]                       computed_crc,
    output logic                             last_of_run
);
    import crsf_pkg::*;

    function automatic logic [7:0] crc8_step(input logic [7:0] crc,
                                             input logic [7:0] b,
                                             input logic [7:0] poly);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++)
        begin
            c = c[7] ? ({c[6:0], 1'b0} ^ poly) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

    logic [7:0]        mem [FRAME_BYTES];

    logic [POS_W-1:0]  count_reg;
    logic [POS_W-1:0]  len_reg;
    logic [7:0]        crc_reg;
    logic [ADDR_W-1:0] rd_idx_reg;

    logic              rd_vld_reg;
    logic [7:0]        rd_byte_reg;
    logic [POS_W-1:0]  rd_pos_reg;
    logic              rd_last_reg;

    logic              out_valid_reg;
    status_t           status_reg;
    logic [7:0]        byte_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [7:0]        crc_out_reg;
    logic              last_reg;

    logic [POS_W-1:0]  cnt_inc;
    logic [POS_W-1:0]  end_pos;
    logic [ADDR_W-1:0] wr_addr;
    logic              advance;
    logic [POS_W-1:0]  emit_pos;
    logic [7:0]        emit_crc;

    assign cnt_inc = count_reg + POS_W'(1);
    assign end_pos = len_reg + POS_W'(1);
    assign advance = !out_valid_reg || !out_stall;

    assign sts.start_hit  = (rx_byte == cfg.sync_value) || (rx_byte == cfg.start_value_a)
                         || (rx_byte == cfg.start_value_b) || (rx_byte == cfg.start_value_c);
    assign sts.len_ok     = (rx_byte != 8'd0)
                         && (rx_byte >= {2'b00, cfg.min_length_byte})
                         && (rx_byte <= {2'b00, cfg.max_length_byte})
                         && (rx_byte <= 8'(LEN_CAP));
    assign sts.data_last  = (cnt_inc >= len_reg);
    assign sts.crc_match  = (rx_byte == crc_reg);
    assign sts.drain_last = (rd_idx_reg == ADDR_W'(end_pos));
    assign sts.advance    = advance;
    // the output register takes a reject only when no drained byte is queued
    assign sts.slot_free  = advance && !rd_vld_reg;

    always_comb
    begin
        unique case (cmd.wr_sel)
            WR_START: wr_addr = ADDR_W'(0);
            WR_LEN:   wr_addr = ADDR_W'(1);
            WR_DATA:  wr_addr = ADDR_W'(count_reg + POS_W'(2));
            default:  wr_addr = ADDR_W'(0);
        endcase
    end

    always_comb
    begin
        unique case (cmd.emit_status)
            ST_BAD_START: emit_pos = POS_W'(0);
            ST_BAD_LEN:   emit_pos = POS_W'(1);
            ST_CRC_ERR:   emit_pos = end_pos;
            default:      emit_pos = POS_W'(0);
        endcase
        emit_crc = (cmd.emit_status == ST_CRC_ERR) ? crc_reg : 8'd0;
    end

    // frame buffer: one write port, registered read for the drain
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[wr_addr] <= rx_byte;
        end
        if (cmd.drain_issue)
        begin
            rd_byte_reg <= mem[rd_idx_reg];
            rd_pos_reg  <= POS_W'(rd_idx_reg);
            rd_last_reg <= sts.drain_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            len_reg       <= '0;
            crc_reg       <= '0;
            rd_idx_reg    <= '0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.wr_en && (cmd.wr_sel == WR_LEN))
            begin
                len_reg    <= rx_byte[POS_W-1:0];
                count_reg  <= '0;
                crc_reg    <= '0;
                rd_idx_reg <= '0;
            end
            else if (cmd.wr_en && (cmd.wr_sel == WR_DATA))
            begin
                count_reg <= cnt_inc;
                if (cmd.crc_step)
                begin
                    crc_reg <= crc8_step(crc_reg, rx_byte, cfg.crc_polynomial);
                end
            end
            if (cmd.drain_issue)
            begin
                rd_idx_reg <= rd_idx_reg + ADDR_W'(1);
            end
            if (advance)
            begin
                out_valid_reg <= rd_vld_reg || cmd.emit;
                rd_vld_reg    <= cmd.drain_issue;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            if (rd_vld_reg)
            begin
                status_reg  <= ST_FRAME;
                byte_reg    <= rd_byte_reg;
                pos_reg     <= rd_pos_reg;
                crc_out_reg <= 8'd0;
                last_reg    <= rd_last_reg;
            end
            else if (cmd.emit)
            begin
                status_reg  <= cmd.emit_status;
                byte_reg    <= rx_byte;
                pos_reg     <= emit_pos;
                crc_out_reg <= emit_crc;
                last_reg    <= 1'b1;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign frame_byte    = byte_reg;
    assign byte_position = pos_reg;
    assign computed_crc  = crc_out_reg;
    assign last_of_run   = last_reg;

    `CRSF_ASSERT_IMP(a_emit_no_queued, cmd.emit, !rd_vld_reg && advance, "reject while drain byte queued")
    `CRSF_ASSERT_IMP(a_issue_moves, cmd.drain_issue, advance, "drain read while output blocked")
    `CRSF_ASSERT_IMP(a_crc_not_last, cmd.crc_step, !sts.data_last, "crc taken over check byte")
    `CRSF_ASSERT_NEXT(a_last_queued, cmd.drain_issue && sts.drain_last, rd_vld_reg && rd_last_reg, "final drain byte lost")

endmodule
`default_nettype wire
